### hdl/swpm_pkg.sv
package swpm_pkg;

  localparam int unsigned NumCfg = 8;

  typedef enum logic [2:0] {
    ActTick  = 3'd0,
    ActLoad  = 3'd1,
    ActSend  = 3'd2,
    ActRecv  = 3'd3,
    ActIdle  = 3'd4,
    ActSleep = 3'd5,
    ActRsv6  = 3'd6,
    ActRsv7  = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CfgLowPulse   = 3'd0,
    CfgOneRest    = 3'd1,
    CfgZeroGap    = 3'd2,
    CfgZeroRest   = 3'd3,
    CfgTurnaround = 3'd4,
    CfgStartTmo   = 3'd5,
    CfgZeroTmo    = 3'd6,
    CfgRetry      = 3'd7
  } cfg_idx_e;

  typedef enum logic [8:0] {
    PhIdle   = 9'b000000001,
    PhTurn   = 9'b000000010,
    PhLow1   = 9'b000000100,
    PhHigh1  = 9'b000001000,
    PhLow2   = 9'b000010000,
    PhRest   = 9'b000100000,
    PhRxFall = 9'b001000000,
    PhRxRise = 9'b010000000,
    PhRxZero = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {
    OpSend = 2'd0,
    OpRecv = 2'd1,
    OpFlag = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTimeout = 2'd1,
    StFailed  = 2'd2
  } status_e;

  localparam logic [7:0] FlagCmd   = 8'h77;
  localparam logic [7:0] FlagRx    = 8'h88;
  localparam logic [7:0] FlagIdle  = 8'hBB;
  localparam logic [7:0] FlagSleep = 8'hCC;
  localparam logic [2:0] RetryDefault = 3'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_in;
    logic [7:0] count;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic [7:0] rx_byte;
    logic [7:0] rx_position;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] low_pulse;
    logic [15:0] one_rest;
    logic [15:0] zero_gap;
    logic [15:0] zero_rest;
    logic [15:0] turnaround;
    logic [15:0] start_tmo;
    logic [15:0] zero_tmo;
    logic [2:0]  retry;
  } cfg_t;

  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

### hdl/swpm_if.sv
interface swpm_in_if;
  logic                valid;
  logic                ready;
  swpm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swpm_out_if;
  logic                valid;
  logic                ready;
  swpm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### hdl/swpm_regs.sv
module swpm_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swpm_cfg_if.sink              cfg,
  output swpm_pkg::cfg_t        cfg_o
);
  swpm_pkg::cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_pulse  <= 16'd4;
      cfg_q.one_rest   <= 16'd28;
      cfg_q.zero_gap   <= 16'd4;
      cfg_q.zero_rest  <= 16'd20;
      cfg_q.turnaround <= 16'd60;
      cfg_q.start_tmo  <= 16'd200;
      cfg_q.zero_tmo   <= 16'd100;
      cfg_q.retry      <= swpm_pkg::RetryDefault;
    end else if (cfg.valid) begin
      unique case (swpm_pkg::cfg_idx_e'(cfg.index))
        swpm_pkg::CfgLowPulse:   cfg_q.low_pulse  <= cfg.wdata;
        swpm_pkg::CfgOneRest:    cfg_q.one_rest   <= cfg.wdata;
        swpm_pkg::CfgZeroGap:    cfg_q.zero_gap   <= cfg.wdata;
        swpm_pkg::CfgZeroRest:   cfg_q.zero_rest  <= cfg.wdata;
        swpm_pkg::CfgTurnaround: cfg_q.turnaround <= cfg.wdata;
        swpm_pkg::CfgStartTmo:   cfg_q.start_tmo  <= cfg.wdata;
        swpm_pkg::CfgZeroTmo:    cfg_q.zero_tmo   <= cfg.wdata;
        swpm_pkg::CfgRetry:      cfg_q.retry      <= cfg.wdata[2:0];
        default: ;
      endcase
    end
  end
endmodule

### hdl/swpm_txmem.sv
module swpm_txmem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/single_wire_pulse_master.sv
// Tick-driven master for one open-drain line with pulse-count bit coding, lsb
// first: a one is one low pulse then a rest, a zero is two low pulses. Every
// accepted input item is one tick and produces exactly one result item in the
// same cycle order; items are taken back to back, one per clock, limited only
// by the output register (a skid buffer holds one result while the sink stalls).
// Loaded bytes sit in a TX_DEPTH x 8 synchronous memory; the byte being sent is
// prefetched into a one-byte holding register while the previous byte shifts
// out, so a byte boundary never waits on the memory read. Send emits flag 0x77
// then the loaded bytes; idle and sleep emit 0xBB and 0xCC; receive emits 0x88
// then decodes count bytes, retrying up to cfg.retry attempts. Configuration
// writes are taken in any cycle and should be made while the block is idle.
module single_wire_pulse_master #(
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  swpm_in_if.sink  in_ch,
  swpm_out_if.source out_ch,
  swpm_cfg_if.sink cfg_ch
);
  localparam int unsigned AddrW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(TX_DEPTH + 1) + 1;

  swpm_pkg::cfg_t cfg;

  swpm_regs u_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  // state
  swpm_pkg::phase_e phase_q, phase_d;
  swpm_pkg::op_e    op_q, op_d;
  logic [7:0]       flag_q, flag_d;
  logic [FillW-1:0] fill_q, fill_d, ptr_q, ptr_d;
  logic [2:0]       bit_q, bit_d;
  logic [15:0]      tmr_q, tmr_d;
  logic [7:0]       shift_q, shift_d, done_cnt_q, done_cnt_d, target_q, target_d;
  logic [2:0]       att_q, att_d;
  logic             zseen_q, zseen_d;
  logic [7:0]       cur_byte_q, cur_byte_d;

  // output skid: main register and one spare
  swpm_pkg::out_item_t out_q, skid_q, res;
  logic out_v_q, skid_v_q;

  logic accept;
  assign in_ch.ready = !skid_v_q;
  assign accept = in_ch.valid && in_ch.ready;

  // memory
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_rdata;

  swpm_txmem #(.Depth(TX_DEPTH), .AddrW(AddrW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_ch.data.byte_in),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // read address: the byte after the one at ptr (ptr 0 is the flag); read
  // issued ahead of need, data taken at byte boundary
  logic rd_pend_q, rd_pend_d;
  logic [7:0] pre_q, pre_d;
  assign mem_raddr = ptr_d[AddrW-1:0];

  logic cur_bit;
  assign cur_bit = cur_byte_q[bit_q];

  logic [15:0] tmr_dec;
  logic        tmr_zero;
  assign tmr_dec  = (tmr_q > 16'd0) ? tmr_q - 16'd1 : 16'd0;
  assign tmr_zero = (tmr_dec == 16'd0);

  logic [FillW-1:0] job_len;
  assign job_len = (op_q == swpm_pkg::OpSend) ? fill_q + FillW'(1) : FillW'(1);

  logic line;
  assign line = in_ch.data.line_level;

  always_comb begin
    phase_d = phase_q; op_d = op_q; flag_d = flag_q; fill_d = fill_q;
    ptr_d = ptr_q; bit_d = bit_q; tmr_d = tmr_q; shift_d = shift_q;
    done_cnt_d = done_cnt_q; target_d = target_q; att_d = att_q;
    zseen_d = zseen_q; cur_byte_d = cur_byte_q;
    rd_pend_d = 1'b0; pre_d = rd_pend_q ? mem_rdata : pre_q;
    mem_we = 1'b0; mem_waddr = fill_q[AddrW-1:0];
    res = '0;

    if (accept) begin
      logic tx_done_ev, rx_ev, rx_b, fail_ev, start_ev;
      tx_done_ev = 1'b0; rx_ev = 1'b0; rx_b = 1'b0; fail_ev = 1'b0; start_ev = 1'b0;
      unique case (phase_q)
        swpm_pkg::PhIdle: begin
          unique case (swpm_pkg::action_e'(in_ch.data.action))
            swpm_pkg::ActLoad: begin
              if (fill_q < FillW'(TX_DEPTH)) begin
                mem_we = 1'b1;
                fill_d = fill_q + FillW'(1);
              end
            end
            swpm_pkg::ActSend: begin
              op_d = swpm_pkg::OpSend; flag_d = swpm_pkg::FlagCmd; start_ev = 1'b1;
            end
            swpm_pkg::ActRecv: begin
              op_d = swpm_pkg::OpRecv; flag_d = swpm_pkg::FlagRx; start_ev = 1'b1;
              target_d = in_ch.data.count;
              att_d = (cfg.retry == 3'd0) ? 3'd1 : cfg.retry;
              done_cnt_d = 8'd0; shift_d = 8'd0;
            end
            swpm_pkg::ActIdle: begin
              op_d = swpm_pkg::OpFlag; flag_d = swpm_pkg::FlagIdle; start_ev = 1'b1;
            end
            swpm_pkg::ActSleep: begin
              op_d = swpm_pkg::OpFlag; flag_d = swpm_pkg::FlagSleep; start_ev = 1'b1;
            end
            default: ;
          endcase
        end
        swpm_pkg::PhTurn: begin
          tmr_d = tmr_dec;
          if (tmr_zero) begin
            phase_d = swpm_pkg::PhLow1; tmr_d = swpm_pkg::at_least_one(cfg.low_pulse);
          end
        end
        swpm_pkg::PhLow1: begin
          tmr_d = tmr_dec;
          if (tmr_zero) begin
            phase_d = swpm_pkg::PhHigh1;
            tmr_d = cur_bit ? swpm_pkg::at_least_one(cfg.one_rest)
                            : swpm_pkg::at_least_one(cfg.zero_gap);
          end
        end
        swpm_pkg::PhHigh1: begin
          tmr_d = tmr_dec;
          if (tmr_zero) begin
            if (cur_bit) tx_done_ev = 1'b1;
            else begin
              phase_d = swpm_pkg::PhLow2; tmr_d = swpm_pkg::at_least_one(cfg.low_pulse);
            end
          end
        end
        swpm_pkg::PhLow2: begin
          tmr_d = tmr_dec;
          if (tmr_zero) begin
            phase_d = swpm_pkg::PhRest; tmr_d = swpm_pkg::at_least_one(cfg.zero_rest);
          end
        end
        swpm_pkg::PhRest: begin
          tmr_d = tmr_dec;
          if (tmr_zero) tx_done_ev = 1'b1;
        end
        swpm_pkg::PhRxFall: begin
          if (!line) begin
            phase_d = swpm_pkg::PhRxRise; tmr_d = swpm_pkg::at_least_one(cfg.start_tmo);
          end else begin
            tmr_d = tmr_dec;
            if (tmr_zero) fail_ev = 1'b1;
          end
        end
        swpm_pkg::PhRxRise: begin
          if (line) begin
            zseen_d = 1'b0; phase_d = swpm_pkg::PhRxZero;
            tmr_d = swpm_pkg::at_least_one(cfg.zero_tmo);
          end else begin
            tmr_d = tmr_dec;
            if (tmr_zero) fail_ev = 1'b1;
          end
        end
        swpm_pkg::PhRxZero: begin
          if (!zseen_q) begin
            if (!line) begin
              zseen_d = 1'b1; tmr_d = swpm_pkg::at_least_one(cfg.zero_tmo);
            end else begin
              tmr_d = tmr_dec;
              if (tmr_zero) begin rx_ev = 1'b1; rx_b = 1'b1; end
            end
          end else if (line) begin
            rx_ev = 1'b1;
          end else begin
            tmr_d = tmr_dec;
            if (tmr_zero) rx_ev = 1'b1;
          end
        end
        default: phase_d = swpm_pkg::PhIdle;
      endcase

      if (tx_done_ev) begin
        bit_d = bit_q + 3'd1;
        phase_d = swpm_pkg::PhLow1; tmr_d = swpm_pkg::at_least_one(cfg.low_pulse);
        if (bit_q == 3'd7) begin
          ptr_d = ptr_q + FillW'(1);
          cur_byte_d = pre_d;
          if (ptr_d >= job_len) begin
            if (op_q == swpm_pkg::OpRecv) begin
              done_cnt_d = 8'd0; shift_d = 8'd0;
              if (target_q == 8'd0) begin
                phase_d = swpm_pkg::PhIdle; tmr_d = '0;
                res.done_res = 1'b1;
              end else begin
                zseen_d = 1'b0; phase_d = swpm_pkg::PhRxFall;
                tmr_d = swpm_pkg::at_least_one(cfg.start_tmo);
              end
            end else begin
              if (op_q == swpm_pkg::OpSend) fill_d = '0;
              phase_d = swpm_pkg::PhIdle; tmr_d = '0;
              res.done_res = 1'b1;
            end
          end
        end else if (bit_q == 3'd6) begin
          rd_pend_d = 1'b1;
        end
      end

      if (rx_ev) begin
        shift_d = shift_q | (8'(rx_b) << bit_q);
        bit_d = bit_q + 3'd1;
        zseen_d = 1'b0; phase_d = swpm_pkg::PhRxFall;
        tmr_d = swpm_pkg::at_least_one(cfg.start_tmo);
        if (bit_q == 3'd7) begin
          res.rx_valid = 1'b1;
          res.rx_byte = shift_d;
          res.rx_position = done_cnt_q;
          done_cnt_d = done_cnt_q + 8'd1;
          shift_d = 8'd0;
          if (done_cnt_d == target_q) begin
            phase_d = swpm_pkg::PhIdle; tmr_d = '0; res.done_res = 1'b1;
          end
        end
      end

      if (fail_ev) begin
        logic [2:0] a;
        a = (att_q > 3'd0) ? att_q - 3'd1 : 3'd0;
        att_d = a;
        if (a > 3'd0) begin
          start_ev = 1'b1;
        end else begin
          phase_d = swpm_pkg::PhIdle; tmr_d = '0; res.done_res = 1'b1;
          res.status = (done_cnt_q > 8'd0) ? swpm_pkg::StFailed : swpm_pkg::StTimeout;
        end
      end

      if (start_ev) begin
        ptr_d = '0; bit_d = 3'd0;
        cur_byte_d = flag_d;
        if (cfg.turnaround == 16'd0) begin
          phase_d = swpm_pkg::PhLow1; tmr_d = swpm_pkg::at_least_one(cfg.low_pulse);
        end else begin
          phase_d = swpm_pkg::PhTurn; tmr_d = cfg.turnaround;
        end
      end

      // prefetch the next byte early in each byte
      if (op_d == swpm_pkg::OpSend && bit_d == 3'd0 && phase_d != swpm_pkg::PhIdle &&
          !rd_pend_d && (start_ev || tx_done_ev)) begin
        rd_pend_d = 1'b1;
      end

      res.drive_enable = (phase_d == swpm_pkg::PhLow1) || (phase_d == swpm_pkg::PhLow2) ||
                         (phase_d == swpm_pkg::PhHigh1) || (phase_d == swpm_pkg::PhRest);
      res.drive_level  = (phase_d == swpm_pkg::PhHigh1) || (phase_d == swpm_pkg::PhRest);
      res.busy_res     = (phase_d != swpm_pkg::PhIdle);
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_v_q && !out_ch.ready) begin
        if (accept) skid_v_q <= 1'b1;
      end else begin
        out_v_q  <= skid_v_q || accept;
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !out_ch.ready) begin
      if (accept) skid_q <= res;
    end else begin
      out_q <= skid_v_q ? skid_q : res;
    end
  end

  assign out_ch.valid = out_v_q;
  assign out_ch.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= swpm_pkg::PhIdle; op_q <= swpm_pkg::OpFlag;
      flag_q <= swpm_pkg::FlagIdle; fill_q <= '0; ptr_q <= '0; bit_q <= '0;
      tmr_q <= '0; shift_q <= '0; done_cnt_q <= '0; target_q <= '0;
      att_q <= '0; zseen_q <= 1'b0; cur_byte_q <= '0;
      rd_pend_q <= 1'b0; pre_q <= '0;
    end else begin
      phase_q <= phase_d; op_q <= op_d; flag_q <= flag_d; fill_q <= fill_d;
      ptr_q <= ptr_d; bit_q <= bit_d; tmr_q <= tmr_d; shift_q <= shift_d;
      done_cnt_q <= done_cnt_d; target_q <= target_d; att_q <= att_d;
      zseen_q <= zseen_d; cur_byte_q <= cur_byte_d;
      rd_pend_q <= rd_pend_d; pre_q <= pre_d;
    end
  end
endmodule

### hdl/swpm_checker.sv
module swpm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input swpm_pkg::out_item_t out_data_i
);
  a_level_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.drive_level |-> out_data_i.drive_enable)
    else $error("driven high without enable");

  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.done_res |-> out_data_i.status == 2'd0)
    else $error("status without done");

  a_rx_not_driving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.rx_valid |-> !out_data_i.drive_enable)
    else $error("receive while driving");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled item changed");
endmodule

bind single_wire_pulse_master swpm_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_data_i (out_ch.data)
);
